### rtl/tgc_pkg.sv
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared types, codes and constants for the touch gesture classifier.
// ----------------------------------------------------------------------------
package tgc_pkg;

    // field widths fixed by the interface
    localparam int POINT_W        = 4;
    localparam int KIND_W         = 2;
    localparam int GESTURE_W      = 3;
    localparam int TAP_W          = 25;
    localparam int SWIPE_W        = 12;
    localparam int MARGIN_W       = 25;
    localparam int CFG_DATA_W     = 25;
    localparam int CFG_IDX_W      = 2;
    localparam int COORD_BITS_DEF = 12;

    // register reset values
    localparam logic [TAP_W-1:0]    TAP_RADIUS_SQ_RST = TAP_W'(400);
    localparam logic [SWIPE_W-1:0]  SWIPE_MIN_RST     = SWIPE_W'(50);
    localparam logic [MARGIN_W-1:0] PINCH_MARGIN_RST  = MARGIN_W'(2000);

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE        = 2'd0,
        CFG_TAP_RADIUS_SQ = 2'd1,
        CFG_SWIPE_MIN     = 2'd2,
        CFG_PINCH_MARGIN  = 2'd3
    } t_cfg_idx;

    // action of the first touch point
    typedef enum logic [KIND_W-1:0] {
        KIND_DOWN  = 2'd0,
        KIND_UP    = 2'd1,
        KIND_MOVE  = 2'd2,
        KIND_OTHER = 2'd3
    } t_kind;

    // gesture codes
    typedef enum logic [GESTURE_W-1:0] {
        G_NONE      = 3'd0,
        G_TAP       = 3'd1,
        G_RIGHT     = 3'd2,
        G_LEFT      = 3'd3,
        G_DOWN      = 3'd4,
        G_UP        = 3'd5,
        G_PINCH_OUT = 3'd6,
        G_PINCH_IN  = 3'd7
    } t_gesture;

    // configuration bundle
    typedef struct packed {
        logic                enable;
        logic [TAP_W-1:0]    tap_radius_sq;
        logic [SWIPE_W-1:0]  swipe_min;
        logic [MARGIN_W-1:0] pinch_margin;
    } t_cfg;

endpackage

### rtl/tgc_cfg_regs.sv
// ----------------------------------------------------------------------------
// tgc_cfg_regs
// Configuration register file, written through its own request channel.
// ----------------------------------------------------------------------------
module tgc_cfg_regs import tgc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // every write request is taken at once
    assign o_cfg_ready = 1'b1;

    // decode the register index
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLE:        n_cfg.enable        = i_cfg_data[0];
                CFG_TAP_RADIUS_SQ: n_cfg.tap_radius_sq = i_cfg_data[TAP_W-1:0];
                CFG_SWIPE_MIN:     n_cfg.swipe_min     = i_cfg_data[SWIPE_W-1:0];
                CFG_PINCH_MARGIN:  n_cfg.pinch_margin  = i_cfg_data[MARGIN_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable        <= 1'b0;
            r_cfg.tap_radius_sq <= TAP_RADIUS_SQ_RST;
            r_cfg.swipe_min     <= SWIPE_MIN_RST;
            r_cfg.pinch_margin  <= PINCH_MARGIN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/tgc_classify.sv
// ----------------------------------------------------------------------------
// tgc_classify
// Gesture decision for one registered event, plus the tracking state
// (start point and previous finger spread) that it updates on commit.
// ----------------------------------------------------------------------------
module tgc_classify import tgc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_commit,
    input  logic [POINT_W-1:0]    i_point_count,
    input  logic [COORD_BITS-1:0] i_first_x,
    input  logic [COORD_BITS-1:0] i_first_y,
    input  logic [KIND_W-1:0]     i_first_kind,
    input  logic [COORD_BITS-1:0] i_second_x,
    input  logic [COORD_BITS-1:0] i_second_y,
    output t_gesture              o_gesture
);

    localparam int C     = COORD_BITS;
    localparam int SQ_W  = 2 * C + 1;
    localparam int CMP_W = ((SQ_W > TAP_W) ? SQ_W : TAP_W) + 1;
    localparam int SW_W  = (C > SWIPE_W) ? C : SWIPE_W;

    logic [C-1:0]    r_start_x;
    logic [C-1:0]    r_start_y;
    logic [SQ_W-1:0] r_prev_spread;

    logic signed [C:0] rel_dx, rel_dy, spr_dx, spr_dy;
    logic [C-1:0]      rel_ax, rel_ay, spr_ax, spr_ay;
    logic [2*C-1:0]    rel_ax_sq, rel_ay_sq, spr_ax_sq, spr_ay_sq;
    logic [SQ_W-1:0]   rel_d2, cur_spread;
    logic [CMP_W-1:0]  cmp_cur, cmp_prev, cmp_margin, cmp_d2, cmp_tap;
    logic [SW_W-1:0]   sw_ax, sw_ay, sw_min;
    logic              is_active, is_single, is_pair, is_down, is_up;
    t_gesture          release_g, pinch_g, g;

    // travel of the release point from the start point
    assign rel_dx = $signed({1'b0, i_first_x}) - $signed({1'b0, r_start_x});
    assign rel_dy = $signed({1'b0, i_first_y}) - $signed({1'b0, r_start_y});
    assign rel_ax = rel_dx[C] ? C'(-rel_dx) : rel_dx[C-1:0];
    assign rel_ay = rel_dy[C] ? C'(-rel_dy) : rel_dy[C-1:0];
    assign rel_ax_sq = rel_ax * rel_ax;
    assign rel_ay_sq = rel_ay * rel_ay;
    assign rel_d2 = SQ_W'(rel_ax_sq) + SQ_W'(rel_ay_sq);

    // spread between the two carried points
    assign spr_dx = $signed({1'b0, i_first_x}) - $signed({1'b0, i_second_x});
    assign spr_dy = $signed({1'b0, i_first_y}) - $signed({1'b0, i_second_y});
    assign spr_ax = spr_dx[C] ? C'(-spr_dx) : spr_dx[C-1:0];
    assign spr_ay = spr_dy[C] ? C'(-spr_dy) : spr_dy[C-1:0];
    assign spr_ax_sq = spr_ax * spr_ax;
    assign spr_ay_sq = spr_ay * spr_ay;
    assign cur_spread = SQ_W'(spr_ax_sq) + SQ_W'(spr_ay_sq);

    // common compare widths
    assign cmp_d2     = CMP_W'(rel_d2);
    assign cmp_tap    = CMP_W'(i_cfg.tap_radius_sq);
    assign cmp_cur    = CMP_W'(cur_spread);
    assign cmp_prev   = CMP_W'(r_prev_spread);
    assign cmp_margin = CMP_W'(i_cfg.pinch_margin);
    assign sw_ax      = SW_W'(rel_ax);
    assign sw_ay      = SW_W'(rel_ay);
    assign sw_min     = SW_W'(i_cfg.swipe_min);

    // release: tap, else swipe along the strictly dominant axis
    always_comb begin
        release_g = G_NONE;
        if (cmp_d2 < cmp_tap) begin
            release_g = G_TAP;
        end else if (sw_ax > sw_ay && sw_ax > sw_min) begin
            release_g = rel_dx[C] ? G_LEFT : G_RIGHT;
        end else if (sw_ay > sw_ax && sw_ay > sw_min) begin
            release_g = rel_dy[C] ? G_UP : G_DOWN;
        end
    end

    // pinch: spread change beyond the margin either way
    always_comb begin
        pinch_g = G_NONE;
        if (cmp_cur > cmp_prev + cmp_margin) begin
            pinch_g = G_PINCH_OUT;
        end else if (cmp_cur + cmp_margin < cmp_prev) begin
            pinch_g = G_PINCH_IN;
        end
    end

    // event qualification
    assign is_active = i_cfg.enable && (i_point_count != '0);
    assign is_single = i_point_count == POINT_W'(1);
    assign is_pair   = i_point_count == POINT_W'(2);
    assign is_down   = t_kind'(i_first_kind) == KIND_DOWN;
    assign is_up     = t_kind'(i_first_kind) == KIND_UP;

    // final gesture select
    always_comb begin
        g = G_NONE;
        if (is_active) begin
            if (is_single && is_up) begin
                g = release_g;
            end else if (is_pair) begin
                g = pinch_g;
            end
        end
    end

    assign o_gesture = g;

    // tracking state, updated when the result is committed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x     <= '0;
            r_start_y     <= '0;
            r_prev_spread <= '0;
        end else if (i_commit && is_active) begin
            if (is_single && is_down) begin
                r_start_x <= i_first_x;
                r_start_y <= i_first_y;
            end
            if (g == G_NONE) begin
                r_prev_spread <= cur_spread;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // disabled or empty events leave the tracking state alone
    a_idle_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_commit && !is_active) |=> ($stable(r_start_x) && $stable(r_prev_spread)))
        else $error("tracking state changed on an inactive event");

    // a reported gesture keeps the previous spread
    a_gesture_keeps_spread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_commit && g != G_NONE) |=> $stable(r_prev_spread))
        else $error("previous spread updated after a gesture");

    // a tap or swipe only comes from a single-point release
    a_release_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (g != G_NONE && g != G_PINCH_OUT && g != G_PINCH_IN) |-> (is_single && is_up))
        else $error("release gesture from a non-release event");
`endif

endmodule

### rtl/touch_gesture_classifier_core.sv
// ----------------------------------------------------------------------------
// touch_gesture_classifier_core
// Classifies touch events as tap, swipe or pinch, one gesture per event.
//
//   channel  direction  handshake                       payload
//   in       input      i_in_valid / o_in_ready          point count, two points, kind
//   out      output     o_out_valid / i_out_ready        gesture code
//   cfg      input      i_cfg_valid / o_cfg_ready        register index, write data
//
// One event per cycle sustained while the output is ready; an accepted
// event waits in the input register, then its result is loaded into
// the result register. The gesture logic lies between the two; tracking
// state is updated at the same edge that loads the result register.
// Reset is synchronous and active low; it clears valids, tracking state
// and restores the register defaults.
// A stalled output holds its result while the input register still takes
// a new event; input backs up only when both registers are full and the
// output is held off.
// ----------------------------------------------------------------------------
module touch_gesture_classifier_core import tgc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // event channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [POINT_W-1:0]    i_point_count,
    input  logic [COORD_BITS-1:0] i_first_x,
    input  logic [COORD_BITS-1:0] i_first_y,
    input  logic [KIND_W-1:0]     i_first_kind,
    input  logic [COORD_BITS-1:0] i_second_x,
    input  logic [COORD_BITS-1:0] i_second_y,
    // gesture channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [GESTURE_W-1:0]  o_gesture,
    // configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg cfg;

    logic                  r_in_valid;
    logic [POINT_W-1:0]    r_point_count;
    logic [COORD_BITS-1:0] r_first_x;
    logic [COORD_BITS-1:0] r_first_y;
    logic [KIND_W-1:0]     r_first_kind;
    logic [COORD_BITS-1:0] r_second_x;
    logic [COORD_BITS-1:0] r_second_y;
    logic                  r_out_valid;
    t_gesture              r_gesture;

    logic                  n_in_valid;
    logic                  n_out_valid;
    logic                  in_take;
    logic                  advance;
    t_gesture              gesture;

    // configuration registers
    tgc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // handshake control
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign in_take     = i_in_valid && o_in_ready;
    assign n_in_valid  = in_take || (r_in_valid && !advance);
    assign n_out_valid = advance || (r_out_valid && !i_out_ready);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_point_count <= i_point_count;
            r_first_x     <= i_first_x;
            r_first_y     <= i_first_y;
            r_first_kind  <= i_first_kind;
            r_second_x    <= i_second_x;
            r_second_y    <= i_second_y;
        end
    end

    // gesture decision and tracking state
    tgc_classify #(
        .COORD_BITS (COORD_BITS)
    ) u_classify (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_commit      (advance),
        .i_point_count (r_point_count),
        .i_first_x     (r_first_x),
        .i_first_y     (r_first_y),
        .i_first_kind  (r_first_kind),
        .i_second_x    (r_second_x),
        .i_second_y    (r_second_y),
        .o_gesture     (gesture)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_gesture <= gesture;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_gesture   = r_gesture;

`ifndef NO_ASSERTIONS
    // an accepted request always lands in the input register
    a_in_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid)
        else $error("accepted event not held in input register");

    // a committed event always produces a pending result
    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("committed event produced no result");

    // an empty input register never back-pressures
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_in_ready)
        else $error("input stalled with empty input register");

    // disabled block reports no gesture
    a_disabled_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !cfg.enable) |=> (r_gesture == G_NONE))
        else $error("gesture reported while disabled");
`endif

endmodule

### verif/tb_touch_gesture_classifier_core.sv
// ----------------------------------------------------------------------------
// tb_touch_gesture_classifier_core
// Self-checking bench for the touch gesture classifier core. A predictor
// tracks start position, previous finger pair and register settings, and
// queues one expected gesture per accepted event request. Directed events
// cover taps, every swipe direction, ties, threshold boundaries and pinches.
// Register settings are swept, extremes included. Random sequences follow:
// down, moves, up, and two-finger runs, plus noise. Both channels idle
// at random, and the output is held off once long enough to back up input.
// ----------------------------------------------------------------------------
module tb_touch_gesture_classifier_core;
    import tgc_pkg::*;

    localparam int COORD_W   = COORD_BITS_DEF;
    localparam int COORD_MAX = (1 << COORD_W) - 1;
    localparam logic [CFG_DATA_W-1:0] TAP_MAX    = {TAP_W{1'b1}};
    localparam logic [CFG_DATA_W-1:0] MARGIN_MAX = {MARGIN_W{1'b1}};

    // expected gesture tracking and result checking
    class gesture_scoreboard;
        logic                enable;
        logic [TAP_W-1:0]    tap_radius_sq;
        logic [SWIPE_W-1:0]  swipe_min;
        logic [MARGIN_W-1:0] pinch_margin;
        logic [COORD_W-1:0]  start_x, start_y;
        logic [COORD_W-1:0]  prev_fx, prev_fy, prev_sx, prev_sy;
        t_gesture            gesture_q[$];
        int                  mismatches;

        function new();
            enable        = 1'b0;
            tap_radius_sq = TAP_RADIUS_SQ_RST;
            swipe_min     = SWIPE_MIN_RST;
            pinch_margin  = PINCH_MARGIN_RST;
            start_x       = '0;
            start_y       = '0;
            prev_fx       = '0;
            prev_fy       = '0;
            prev_sx       = '0;
            prev_sy       = '0;
            mismatches    = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ENABLE:        enable        = data[0];
                CFG_TAP_RADIUS_SQ: tap_radius_sq = data[TAP_W-1:0];
                CFG_SWIPE_MIN:     swipe_min     = data[SWIPE_W-1:0];
                CFG_PINCH_MARGIN:  pinch_margin  = data[MARGIN_W-1:0];
                default: ;
            endcase
        endfunction

        function longint spread_sq(logic [COORD_W-1:0] ax, logic [COORD_W-1:0] ay,
                                   logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by);
            longint dx;
            longint dy;
            dx = longint'(ax) - longint'(bx);
            dy = longint'(ay) - longint'(by);
            return dx * dx + dy * dy;
        endfunction

        // release classified by travel from the latched start
        function t_gesture classify_release(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
            longint dx, dy, d2, ax, ay;
            dx = longint'(x) - longint'(start_x);
            dy = longint'(y) - longint'(start_y);
            d2 = dx * dx + dy * dy;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            if (d2 < longint'(tap_radius_sq))
                return G_TAP;
            if (ax > ay && ax > longint'(swipe_min))
                return (dx > 0) ? G_RIGHT : G_LEFT;
            if (ay > ax && ay > longint'(swipe_min))
                return (dy > 0) ? G_DOWN : G_UP;
            return G_NONE;
        endfunction

        function void note_event(logic [POINT_W-1:0] count, logic [COORD_W-1:0] fx,
                                 logic [COORD_W-1:0] fy, t_kind kind,
                                 logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy);
            t_gesture g;
            longint   cur, prv, m;
            g = G_NONE;
            if (enable && count != 0) begin
                if (count == 1) begin
                    if (kind == KIND_DOWN) begin
                        start_x = fx;
                        start_y = fy;
                    end else if (kind == KIND_UP) begin
                        g = classify_release(fx, fy);
                    end
                end else if (count == 2) begin
                    cur = spread_sq(fx, fy, sx, sy);
                    prv = spread_sq(prev_fx, prev_fy, prev_sx, prev_sy);
                    m   = longint'(pinch_margin);
                    if (cur > prv + m)
                        g = G_PINCH_OUT;
                    else if (cur < prv - m)
                        g = G_PINCH_IN;
                end
                // pair kept unless a gesture fired
                if (g == G_NONE) begin
                    prev_fx = fx;
                    prev_fy = fy;
                    prev_sx = sx;
                    prev_sy = sy;
                end
            end
            gesture_q.push_back(g);
        endfunction

        function void check_gesture(logic [GESTURE_W-1:0] got);
            t_gesture want;
            if (gesture_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected gesture %0d with nothing pending", got);
                return;
            end
            want = gesture_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("gesture mismatch: expected %0d (%s) got %0d",
                             want, want.name(), got);
            end
        endfunction

        function int outstanding();
            return gesture_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [POINT_W-1:0]    i_point_count;
    logic [COORD_W-1:0]    i_first_x;
    logic [COORD_W-1:0]    i_first_y;
    logic [KIND_W-1:0]     i_first_kind;
    logic [COORD_W-1:0]    i_second_x;
    logic [COORD_W-1:0]    i_second_y;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [GESTURE_W-1:0]  o_gesture;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gesture_scoreboard sb = new();

    bit tx_quiet;
    bit rx_quiet;
    bit rx_hold_req;
    int events_sent;

    touch_gesture_classifier_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_point_count (i_point_count),
        .i_first_x     (i_first_x),
        .i_first_y     (i_first_y),
        .i_first_kind  (i_first_kind),
        .i_second_x    (i_second_x),
        .i_second_y    (i_second_y),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_gesture     (o_gesture),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // coordinate clamped into range
    function automatic logic [COORD_W-1:0] coord(int v);
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return COORD_MAX[COORD_W-1:0];
        return v[COORD_W-1:0];
    endfunction

    function automatic int srange(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic logic [COORD_W-1:0] any_coord();
        return coord(int'($urandom_range(0, COORD_MAX)));
    endfunction

    // one event request, then the sender's idle gap
    task automatic send_event(logic [POINT_W-1:0] count, logic [COORD_W-1:0] fx,
                              logic [COORD_W-1:0] fy, t_kind kind,
                              logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy);
        logic hit;
        int   gap;
        i_in_valid    <= 1'b1;
        i_point_count <= count;
        i_first_x     <= fx;
        i_first_y     <= fy;
        i_first_kind  <= kind;
        i_second_x    <= sx;
        i_second_y    <= sy;
        do begin
            @(negedge i_clk);
            hit = o_in_ready;
            @(posedge i_clk);
        end while (!hit);
        sb.note_event(count, fx, fy, kind, sx, sy);
        events_sent++;
        gap = tx_quiet ? 0 : int'($urandom_range(0, 11));
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop offering and wait for every pending gesture
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
    endtask

    // write all four registers back to back
    task automatic load_config(logic [CFG_DATA_W-1:0] en, logic [CFG_DATA_W-1:0] tap,
                               logic [CFG_DATA_W-1:0] swipe,
                               logic [CFG_DATA_W-1:0] margin);
        t_cfg_idx              order[4];
        logic [CFG_DATA_W-1:0] vals[4];
        logic                  hit;
        order = '{CFG_ENABLE, CFG_TAP_RADIUS_SQ, CFG_SWIPE_MIN, CFG_PINCH_MARGIN};
        vals  = '{en, tap, swipe, margin};
        for (int r = 0; r < 4; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= order[r];
            i_cfg_data  <= vals[r];
            do begin
                @(negedge i_clk);
                hit = o_cfg_ready;
                @(posedge i_clk);
            end while (!hit);
            sb.write_reg(order[r], vals[r]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // down, up to two move or spare-kind events, then a release at a chosen travel
    task automatic swipe_sequence();
        int x0, y0, dx, dy, d;
        x0 = int'($urandom_range(0, COORD_MAX));
        y0 = int'($urandom_range(0, COORD_MAX));
        send_event(1, coord(x0), coord(y0), KIND_DOWN, any_coord(), any_coord());
        repeat ($urandom_range(0, 2))
            send_event(1, coord(x0 + srange(200)), coord(y0 + srange(200)),
                       $urandom_range(0, 1) ? KIND_MOVE : KIND_OTHER,
                       any_coord(), any_coord());
        case ($urandom_range(0, 3))
            0: begin
                dx = srange(25);
                dy = srange(25);
            end
            1: begin
                dx = srange(120);
                dy = srange(120);
            end
            2: begin
                dx = srange(COORD_MAX);
                dy = srange(COORD_MAX);
            end
            default: begin
                // equal travel on both axes
                d  = int'($urandom_range(0, 300));
                dx = $urandom_range(0, 1) ? d : -d;
                dy = $urandom_range(0, 1) ? d : -d;
            end
        endcase
        send_event(1, coord(x0 + dx), coord(y0 + dy), KIND_UP, any_coord(), any_coord());
    endtask

    // two-finger run with a drifting spread
    task automatic pinch_sequence();
        int cx, cy, rx, ry, n;
        cx = int'($urandom_range(0, COORD_MAX));
        cy = int'($urandom_range(0, COORD_MAX));
        rx = int'($urandom_range(0, 1500));
        ry = int'($urandom_range(0, 1500));
        n  = int'($urandom_range(2, 5));
        repeat (n) begin
            if ($urandom_range(0, 3) == 0) begin
                rx = int'($urandom_range(0, 2000));
                ry = int'($urandom_range(0, 2000));
            end else begin
                rx = rx + srange(150);
                ry = ry + srange(150);
            end
            send_event(2, coord(cx - rx), coord(cy - ry), t_kind'($urandom_range(0, 3)),
                       coord(cx + rx), coord(cy + ry));
        end
    endtask

    task automatic noise_event();
        send_event(POINT_W'($urandom_range(0, 15)), any_coord(), any_coord(),
                   t_kind'($urandom_range(0, 3)), any_coord(), any_coord());
    endtask

    task automatic run_random(int count);
        int target;
        int pick;
        target = events_sent + count;
        while (events_sent < target) begin
            tx_quiet = ($urandom_range(0, 4) == 0);
            pick     = int'($urandom_range(0, 99));
            if (pick < 45)
                swipe_sequence();
            else if (pick < 80)
                pinch_sequence();
            else
                noise_event();
        end
    endtask

    // gesture receiver with random stalls and an occasional long hold
    initial begin
        logic hit;
        logic [GESTURE_W-1:0] got;
        int gap;
        int taken;
        taken = 0;
        wait (i_rst_n);
        forever begin
            if (rx_hold_req) begin
                i_out_ready <= 1'b0;
                repeat (60) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else begin
                gap = rx_quiet ? 0 : int'($urandom_range(0, 11));
                if (gap != 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            do begin
                @(negedge i_clk);
                hit = o_out_valid;
                got = o_gesture;
                @(posedge i_clk);
            end while (!hit);
            sb.check_gesture(got);
            taken++;
            if (taken % 40 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
        end
    end

    // run limit
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // main sequence
    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_point_count = '0;
        i_first_x     = '0;
        i_first_y     = '0;
        i_first_kind  = KIND_DOWN;
        i_second_x    = '0;
        i_second_y    = '0;
        i_out_ready   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_ENABLE;
        i_cfg_data    = '0;
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        rx_hold_req   = 1'b0;
        events_sent   = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // disabled after reset
        send_event(1, 100, 100, KIND_DOWN, 0, 0);
        send_event(2, 0, 0, KIND_UP, COORD_MAX, COORD_MAX);
        drain();
        load_config(1, 400, 50, 2000);

        // no points
        send_event(0, COORD_MAX, COORD_MAX, KIND_UP, COORD_MAX, COORD_MAX);
        // tap in place, then axis tie at full travel
        send_event(1, 0, 0, KIND_DOWN, COORD_MAX, COORD_MAX);
        send_event(1, 0, 0, KIND_UP, 0, 0);
        send_event(1, COORD_MAX, COORD_MAX, KIND_UP, 0, 0);
        // each swipe direction at full travel
        send_event(1, COORD_MAX, 0, KIND_UP, 0, 0);
        send_event(1, COORD_MAX, 0, KIND_DOWN, 0, 0);
        send_event(1, 0, 0, KIND_UP, 0, 0);
        send_event(1, 0, 0, KIND_DOWN, 0, 0);
        send_event(1, 0, COORD_MAX, KIND_UP, 0, 0);
        send_event(1, 0, COORD_MAX, KIND_DOWN, 0, 0);
        send_event(1, 0, 0, KIND_UP, 0, 0);
        // swipe minimum and tap radius boundaries
        send_event(1, 100, 100, KIND_DOWN, 0, 0);
        send_event(1, 151, 100, KIND_UP, 0, 0);
        send_event(1, 150, 100, KIND_UP, 0, 0);
        send_event(1, 119, 100, KIND_UP, 0, 0);
        send_event(1, 120, 100, KIND_UP, 0, 0);
        // move and the spare kind code
        send_event(1, 2000, 2000, KIND_MOVE, 1, 1);
        send_event(1, COORD_MAX, COORD_MAX, KIND_OTHER, 0, 0);
        // pinches against the stored pair
        send_event(2, 2048, 2048, KIND_DOWN, 2049, 2048);
        send_event(2, 0, 0, KIND_MOVE, COORD_MAX, COORD_MAX);
        send_event(2, 2000, 2000, KIND_UP, 2001, 2000);
        // many points store the carried pair
        send_event(15, 2000, 2000, KIND_OTHER, 2000, 2000);
        send_event(2, 0, 0, KIND_MOVE, COORD_MAX, COORD_MAX);
        send_event(3, COORD_MAX, 0, KIND_DOWN, 0, COORD_MAX);
        drain();

        // settings sweep
        load_config(1, 400, 50, 2000);
        run_random(150);
        drain();
        load_config(1, 0, 0, 0);
        run_random(120);
        drain();
        load_config(1, TAP_MAX, COORD_MAX, MARGIN_MAX);
        run_random(80);
        drain();
        load_config(1, 1, COORD_MAX, 1);
        run_random(80);
        drain();
        load_config(0, 400, 50, 2000);
        run_random(60);
        drain();

        // long output hold while events keep coming
        load_config(1, $urandom_range(0, 20000), $urandom_range(0, 300),
                    $urandom_range(0, 300000));
        rx_hold_req = 1'b1;
        tx_quiet    = 1'b1;
        repeat (30)
            noise_event();
        run_random(80);
        drain();
        run_random(100);
        drain();

        // upper data bits set where the register ignores them
        load_config(($urandom & MARGIN_MAX & ~CFG_DATA_W'(1)) | 1,
                    $urandom_range(0, 50000),
                    ($urandom & MARGIN_MAX & ~CFG_DATA_W'(COORD_MAX)) |
                        $urandom_range(0, COORD_MAX),
                    $urandom_range(0, 2000000));
        run_random(180);
        drain();

        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
rtl/tgc_pkg.sv
rtl/tgc_cfg_regs.sv
rtl/tgc_classify.sv
rtl/touch_gesture_classifier_core.sv
verif/tb_touch_gesture_classifier_core.sv
